// ===== rtl/core/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants for the greedy box suppression block: field widths,
// register reset value and the widths of the shared multiplier.
// ----------------------------------------------------------------------------
package gbs_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_KEPT_DEF   = 256;
    localparam int MAX_BOXES_DEF  = 4096;
    localparam int COORD_BITS_DEF = 14;

    // Box width and height are always 13-bit unsigned pixel counts.
    localparam int DIM_BITS = 13;
    localparam int AREA_W   = 2 * DIM_BITS;
    // Union of two areas minus their intersection never exceeds the sum.
    localparam int UNI_W    = AREA_W + 1;

    // Overlap threshold register, a fraction of 256.
    localparam int              THR_W     = 9;
    localparam logic [THR_W-1:0] THR_RESET = 9'd115;

    // Shared multiplier: operand A carries the wide union, operand B a
    // dimension or the threshold.
    localparam int MULA_W = UNI_W;
    localparam int MULB_W = DIM_BITS;
    localparam int MUL_W  = MULA_W + MULB_W;

    // Width of threshold * union, the right-hand side of the overlap test.
    localparam int PROD_W = THR_W + UNI_W;

endpackage

// ===== rtl/core/gbs_table.sv =====
// ----------------------------------------------------------------------------
// gbs_table
// Kept-box table: one write port and one registered read port.
// Each entry holds a kept box and its area.
// ----------------------------------------------------------------------------
module gbs_table
    import gbs_pkg::*;
#(
    parameter int DEPTH  = MAX_KEPT_DEF,
    parameter int DATA_W = 2 * COORD_BITS_DEF + 2 * DIM_BITS + AREA_W
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                    wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                    rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/gbs_geom.sv =====
// ----------------------------------------------------------------------------
// gbs_geom
// Overlap extents of two boxes: the width and height of their intersection,
// zero on an axis where the boxes only touch or do not meet.
// ----------------------------------------------------------------------------
module gbs_geom
    import gbs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic        [DIM_BITS-1:0]   a_w,
    input  logic        [DIM_BITS-1:0]   a_h,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic        [DIM_BITS-1:0]   b_w,
    input  logic        [DIM_BITS-1:0]   b_h,
    output logic        [DIM_BITS-1:0]   ovl_w,
    output logic        [DIM_BITS-1:0]   ovl_h
);

    // Edge plus extent must hold without overflow.
    localparam int EXT_W = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1) + 1;

    function automatic logic [DIM_BITS-1:0] axis_overlap(
        input logic signed [COORD_BITS-1:0] p0,
        input logic        [DIM_BITS-1:0]   len0,
        input logic signed [COORD_BITS-1:0] p1,
        input logic        [DIM_BITS-1:0]   len1
    );
        logic signed [EXT_W-1:0] s0;
        logic signed [EXT_W-1:0] s1;
        logic signed [EXT_W-1:0] e0;
        logic signed [EXT_W-1:0] e1;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] diff;
        s0   = EXT_W'(p0);
        s1   = EXT_W'(p1);
        e0   = s0 + signed'(EXT_W'(len0));
        e1   = s1 + signed'(EXT_W'(len1));
        lo   = (s0 > s1) ? s0 : s1;
        hi   = (e0 < e1) ? e0 : e1;
        diff = hi - lo;
        // The overlap is never longer than either extent, so it fits DIM_BITS.
        if (hi > lo) begin
            return diff[DIM_BITS-1:0];
        end
        return '0;
    endfunction

    assign ovl_w = axis_overlap(a_x, a_w, b_x, b_w);
    assign ovl_h = axis_overlap(a_y, a_h, b_y, b_h);

endmodule

// ===== rtl/core/gbs_mult.sv =====
// ----------------------------------------------------------------------------
// gbs_mult
// Shared multiplier with a registered product. It serves the box area,
// the intersection area and the threshold scaling of the union in turn.
// ----------------------------------------------------------------------------
module gbs_mult
    import gbs_pkg::*;
(
    input  logic              aclk,
    input  logic [MULA_W-1:0] op_a,
    input  logic [MULB_W-1:0] op_b,
    output logic [MUL_W-1:0]  prod
);

    logic [MUL_W-1:0] prod_reg;
    logic [MUL_W-1:0] prod_next;

    assign prod_next = MUL_W'(op_a) * MUL_W'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression over score-sorted boxes. Each box is tested
// against every kept box of the current set with an exact integer IoU test,
// intersection * 256 > threshold * union, and reported as kept or suppressed.
//
//   Channel   Dir   Contents
//   s_axis    in    tdata: box_x, box_y, box_width, box_height; tlast: set_end
//   m_axis    out   tdata: kept, box_index, table_overflow; tlast: last_of_set
//   cfg       in    cfg_wr_data: overlap_threshold, written when cfg_wr_en
//
// With a ready receiver a kept box goes from accept through the area step and
// one comparison with each kept box of its set before the next accept. A
// suppressed box stops its comparisons at the first kept box that suppresses
// it. Each comparison is six steps through the one shared multiplier and the
// single read port of the kept table.
// Reset (aresetn low, synchronous) empties the table and sets the threshold
// to 115. A stalled result holds the block before its next accept.
// ----------------------------------------------------------------------------
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_BOXES),
    localparam int S_DATA_W  = ((2 * COORD_BITS + 2 * DIM_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((IDX_W + 2 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Threshold register.
    input  logic                cfg_wr_en,
    input  logic [THR_W-1:0]    cfg_wr_data,
    // Boxes in.
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata, from bit 0: box_x, box_y, box_width, box_height, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    // Results out.
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata, from bit 0: kept, box_index, table_overflow, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int ENT_W   = 2 * COORD_BITS + 2 * DIM_BITS + AREA_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_AREA  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_GEOM  = 9'b000001000,
        ST_INTER = 9'b000010000,
        ST_UNION = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_CMP   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] boxcnt_reg, boxcnt_next;
    logic             keep_reg, keep_next;
    logic             m_valid_reg, m_valid_next;

    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic [DIM_BITS-1:0] cw_reg, cw_next;
    logic [DIM_BITS-1:0] ch_reg, ch_next;
    logic                last_reg, last_next;
    logic [AREA_W-1:0]   area_reg, area_next;
    logic [DIM_BITS-1:0] dx_reg, dx_next;
    logic [DIM_BITS-1:0] dy_reg, dy_next;
    logic [AREA_W-1:0]   inter_reg, inter_next;
    logic [UNI_W-1:0]    uni_reg, uni_next;
    logic                okept_reg, okept_next;
    logic [IDX_W-1:0]    oidx_reg, oidx_next;
    logic                oovf_reg, oovf_next;
    logic                olast_reg, olast_next;

    logic                s_accept;
    logic                out_free;
    logic                table_full;
    logic                out_load;

    logic [ENT_W-1:0]    rd_data;
    logic [ENT_W-1:0]    wr_data;
    logic                wr_en;

    logic signed [COORD_BITS-1:0] kx;
    logic signed [COORD_BITS-1:0] ky;
    logic [DIM_BITS-1:0] kw;
    logic [DIM_BITS-1:0] kh;
    logic [AREA_W-1:0]   karea;
    logic [DIM_BITS-1:0] ovl_w;
    logic [DIM_BITS-1:0] ovl_h;

    logic [MULA_W-1:0]   mul_a;
    logic [MULB_W-1:0]   mul_b;
    logic [MUL_W-1:0]    mul_p;
    logic [PROD_W-1:0]   scaled_union;
    logic [PROD_W-1:0]   scaled_inter;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign table_full = (cnt_reg == CNT_W'(MAX_KEPT));
    assign out_load   = (state_reg == ST_DONE) && out_free;

    // Kept-box entry layout, from bit 0: x, y, width, height, area.
    assign kx    = rd_data[COORD_BITS-1:0];
    assign ky    = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign kw    = rd_data[2*COORD_BITS+DIM_BITS-1:2*COORD_BITS];
    assign kh    = rd_data[2*COORD_BITS+2*DIM_BITS-1:2*COORD_BITS+DIM_BITS];
    assign karea = rd_data[ENT_W-1:2*COORD_BITS+2*DIM_BITS];

    assign wr_data = {area_reg, ch_reg, cw_reg, cy_reg, cx_reg};
    assign wr_en   = out_load && keep_reg && !table_full;

    gbs_table #(
        .DEPTH  (MAX_KEPT),
        .DATA_W (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    gbs_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .a_x   (cx_reg),
        .a_y   (cy_reg),
        .a_w   (cw_reg),
        .a_h   (ch_reg),
        .b_x   (kx),
        .b_y   (ky),
        .b_w   (kw),
        .b_h   (kh),
        .ovl_w (ovl_w),
        .ovl_h (ovl_h)
    );

    // Operand selection for the shared multiplier, by sequencer step.
    always_comb begin
        case (state_reg)
            ST_AREA: begin
                mul_a = MULA_W'(cw_reg);
                mul_b = ch_reg;
            end
            ST_INTER: begin
                mul_a = MULA_W'(dx_reg);
                mul_b = dy_reg;
            end
            ST_SCALE: begin
                mul_a = uni_reg;
                mul_b = MULB_W'(thr_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gbs_mult u_mult (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign scaled_union = mul_p[PROD_W-1:0];
    assign scaled_inter = PROD_W'({inter_reg, 8'b0});

    always_comb begin
        state_next   = state_reg;
        thr_next     = thr_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        boxcnt_next  = boxcnt_reg;
        keep_next    = keep_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cw_next      = cw_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        area_next    = area_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        inter_next   = inter_reg;
        uni_next     = uni_reg;
        okept_next   = okept_reg;
        oidx_next    = oidx_reg;
        oovf_next    = oovf_reg;
        olast_next   = olast_reg;

        if (cfg_wr_en) begin
            thr_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cx_next    = s_tdata[COORD_BITS-1:0];
                    cy_next    = s_tdata[2*COORD_BITS-1:COORD_BITS];
                    cw_next    = s_tdata[2*COORD_BITS+DIM_BITS-1:2*COORD_BITS];
                    ch_next    = s_tdata[2*COORD_BITS+2*DIM_BITS-1:2*COORD_BITS+DIM_BITS];
                    last_next  = s_tlast;
                    keep_next  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_AREA;
                end
            end
            ST_AREA: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                // The box area from the first multiply is ready here.
                if (idx_reg == '0) begin
                    area_next = mul_p[AREA_W-1:0];
                end
                if (idx_reg == cnt_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_GEOM;
                end
            end
            ST_GEOM: begin
                dx_next    = ovl_w;
                dy_next    = ovl_h;
                state_next = ST_INTER;
            end
            ST_INTER: begin
                state_next = ST_UNION;
            end
            ST_UNION: begin
                inter_next = mul_p[AREA_W-1:0];
                uni_next   = UNI_W'(area_reg) + UNI_W'(karea) - UNI_W'(mul_p[AREA_W-1:0]);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // One suppressing kept box settles the answer.
                if (scaled_inter > scaled_union) begin
                    keep_next  = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    okept_next   = keep_reg;
                    oidx_next    = boxcnt_reg;
                    oovf_next    = keep_reg && table_full;
                    olast_next   = last_reg;
                    if (keep_reg && !table_full) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (boxcnt_reg != IDX_W'(MAX_BOXES - 1)) begin
                        boxcnt_next = boxcnt_reg + 1'b1;
                    end
                    if (last_reg) begin
                        cnt_next    = '0;
                        boxcnt_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THR_RESET;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            boxcnt_reg  <= '0;
            keep_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            boxcnt_reg  <= boxcnt_next;
            keep_reg    <= keep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cw_reg    <= cw_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        area_reg  <= area_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        inter_reg <= inter_next;
        uni_reg   <= uni_next;
        okept_reg <= okept_next;
        oidx_reg  <= oidx_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({oovf_reg, oidx_reg, okept_reg});
    assign m_tlast  = olast_reg;

    // The kept count never passes the table depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count exceeds table depth");

    // The comparison walk never reads past the filled part of the table.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> idx_reg <= cnt_reg)
        else $error("comparison index beyond kept count");

    // An overflow report always belongs to a kept box.
    a_ovf_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && oovf_reg |-> okept_reg)
        else $error("overflow flagged on a suppressed box");

    // Overflow is raised only when the table was full at the result load.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && keep_reg && !table_full |=> !oovf_reg)
        else $error("overflow flagged with room in the table");

    // An accepted box blocks the input until its result is loaded.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input ready right after an accepted beat");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for greedy_box_suppression. Boxes go in on the s_ stream and
// each result beat coming out of the m_ stream is compared field by field with
// a behavioral prediction of greedy IoU suppression. The run covers directed
// geometry cases, a sweep of overlap thresholds, a full kept table, a long set
// of repeated boxes, a long receiver hold-off, and random sets.
// ----------------------------------------------------------------------------
module tb;
    import gbs_pkg::*;

    localparam int KEPT_DEPTH = MAX_KEPT_DEF;
    localparam int BOX_LIMIT  = MAX_BOXES_DEF;

    typedef struct packed {
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic signed [13:0]  y;
        logic signed [13:0]  x;
    } nms_box_t;

    typedef struct {
        bit        kept;
        bit [11:0] idx;
        bit        ovf;
        bit        last;
    } nms_result_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [THR_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    // tdata, from bit 0: box_x, box_y, box_width, box_height, zero fill
    logic [55:0]       s_tdata     = '0;
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    // tdata, from bit 0: kept, box_index, table_overflow, zero fill
    logic [15:0]       m_tdata;
    logic              m_tlast;

    greedy_box_suppression DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predicted state of the suppression engine.
    nms_box_t          kept_tbl [KEPT_DEPTH];
    longint            kept_area [KEPT_DEPTH];
    int                kept_num  = 0;
    int                set_pos   = 0;
    logic [THR_W-1:0]  thr_model = THR_RESET;

    nms_result_t       verdict_q [$];

    bit tx_idle_en  = 1'b0;
    bit rx_stall_en = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int rx_stall_left = 0;

    int err_cnt      = 0;
    int boxes_sent   = 0;
    int results_seen = 0;
    int kept_seen    = 0;
    int supp_seen    = 0;
    int ovf_seen     = 0;
    int sets_closed  = 0;
    int thr_writes   = 0;
    int max_idx_seen = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t, result %0d: %s got %0d expected %0d",
                 $realtime, results_seen, what, got, want);
        err_cnt++;
    endtask

    function automatic nms_box_t mk_box(input int x, input int y, input int w, input int h);
        nms_box_t b;
        b.x = 14'(x);
        b.y = 14'(y);
        b.w = 13'(w);
        b.h = 13'(h);
        return b;
    endfunction

    // Greedy suppression of one box against the kept boxes of the open set.
    function automatic nms_result_t predict_box(input nms_box_t b, input bit last);
        nms_result_t r;
        longint bx, by, bw, bh, area;
        longint kx, ky, kw, kh, lft, top, rgt, bot, inter, uni;
        bx = $signed(b.x);
        by = $signed(b.y);
        bw = b.w;
        bh = b.h;
        area = bw * bh;
        r.kept = 1'b1;
        r.ovf  = 1'b0;
        r.last = last;
        r.idx  = 12'(set_pos);
        for (int i = 0; i < kept_num; i++) begin
            kx = $signed(kept_tbl[i].x);
            ky = $signed(kept_tbl[i].y);
            kw = kept_tbl[i].w;
            kh = kept_tbl[i].h;
            lft = (bx > kx) ? bx : kx;
            top = (by > ky) ? by : ky;
            rgt = (bx + bw < kx + kw) ? bx + bw : kx + kw;
            bot = (by + bh < ky + kh) ? by + bh : ky + kh;
            inter = (rgt <= lft || bot <= top) ? 0 : (rgt - lft) * (bot - top);
            uni = area + kept_area[i] - inter;
            if (inter * 256 > longint'(thr_model) * uni)
                r.kept = 1'b0;
        end
        if (r.kept) begin
            if (kept_num < KEPT_DEPTH) begin
                kept_tbl[kept_num]  = b;
                kept_area[kept_num] = area;
                kept_num++;
            end else begin
                r.ovf = 1'b1;
            end
        end
        if (set_pos < BOX_LIMIT - 1)
            set_pos++;
        if (last) begin
            kept_num = 0;
            set_pos  = 0;
        end
        return r;
    endfunction

    task automatic send_box(input nms_box_t b, input bit last);
        nms_result_t want;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b.h, b.w, b.y, b.x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_box(b, last);
        verdict_q = {verdict_q, want};
        boxes_sent++;
    endtask

    // Stop offering boxes and wait until every pending result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (verdict_q.size() != 0);
    endtask

    task automatic write_threshold(input int value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= THR_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        thr_model = THR_W'(value);
        thr_writes++;
    endtask

    // Result side: ready with random stall bursts, long hold-offs on request,
    // and the scoreboard check of every result beat.
    always @(posedge aclk) begin : result_side
        nms_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch("result beat with nothing pending, kept", m_tdata[0], 0);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.kept)
                    report_mismatch("kept", m_tdata[0], want.kept);
                if (m_tdata[12:1] !== want.idx)
                    report_mismatch("box_index", m_tdata[12:1], want.idx);
                if (m_tdata[13] !== want.ovf)
                    report_mismatch("table_overflow", m_tdata[13], want.ovf);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_set", m_tlast, want.last);
                if (want.kept) kept_seen++; else supp_seen++;
                if (want.ovf) ovf_seen++;
                if (want.last) sets_closed++;
                if (want.idx > max_idx_seen) max_idx_seen = want.idx;
            end
        end
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Geometry corner cases at the reset threshold.
    task automatic test_directed();
        send_box(mk_box(0, 0, 100, 100), 1'b0);
        send_box(mk_box(0, 0, 100, 100), 1'b0);      // identical, suppressed
        send_box(mk_box(100, 0, 100, 100), 1'b0);    // touches on the right
        send_box(mk_box(0, 100, 100, 100), 1'b0);    // touches below
        send_box(mk_box(10, 10, 100, 100), 1'b0);
        send_box(mk_box(50, 0, 100, 100), 1'b0);
        send_box(mk_box(-8192, -8192, 8191, 8191), 1'b0);
        send_box(mk_box(8191, 8191, 8191, 8191), 1'b0);
        send_box(mk_box(500, 500, 0, 0), 1'b0);
        send_box(mk_box(500, 500, 0, 0), 1'b0);      // two empty boxes, zero union
        send_box(mk_box(-8192, 8191, 0, 8191), 1'b0);
        send_box(mk_box(0, 0, 8191, 8191), 1'b0);
        send_box(mk_box(-1, -1, 8191, 8191), 1'b0);
        send_box(mk_box(1000, -1000, 0, 8191), 1'b1);
        // The next set starts over at index zero with an empty table.
        send_box(mk_box(0, 0, 100, 100), 1'b0);
        send_box(mk_box(5, 5, 100, 100), 1'b0);
        send_box(mk_box(-8192, 0, 1, 1), 1'b1);
        send_box(mk_box(0, 0, 100, 100), 1'b1);
    endtask

    // Thresholds from zero up through values above 256.
    task automatic test_threshold_sweep();
        int thr_list [8] = '{0, 1, 128, 255, 256, 257, 511, 115};
        foreach (thr_list[i]) begin
            write_threshold(thr_list[i]);
            send_box(mk_box(0, 0, 64, 64), 1'b0);
            send_box(mk_box(0, 0, 64, 64), 1'b0);
            send_box(mk_box(63, 63, 64, 64), 1'b0);
            send_box(mk_box(16, 0, 64, 64), 1'b0);
            send_box(mk_box(10, 10, 0, 0), 1'b0);
            send_box(mk_box(32, 32, 8, 8), 1'b1);
        end
    endtask

    // Fill the kept table, then keep boxes that no longer fit.
    task automatic test_table_full();
        write_threshold(115);
        for (int i = 0; i < KEPT_DEPTH; i++)
            send_box(mk_box((i % 16) * 20, (i / 16) * 20, 10, 10), 1'b0);
        send_box(mk_box(400, 400, 10, 10), 1'b0);
        send_box(mk_box(0, 0, 10, 10), 1'b0);
        // The overflowed box was never stored, so its twin is kept too.
        send_box(mk_box(400, 400, 10, 10), 1'b0);
        send_box(mk_box(2000, 2000, 5, 5), 1'b1);
    endtask

    // One long set of identical boxes, of which only the first one is kept, then a set of one box.
    task automatic test_long_set();
        for (int i = 0; i < 120; i++)
            send_box(mk_box(0, 0, 16, 16), i == 119);
        send_box(mk_box(0, 0, 16, 16), 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering boxes; then the sender
    // waits for every result before going on.
    task automatic test_backpressure();
        rx_hold_req = 400;
        for (int i = 0; i < 24; i++)
            send_box(mk_box(i * 30, 0, 20 + i, 20), i == 23);
        drain_results();
        for (int i = 0; i < 8; i++)
            send_box(mk_box(0, i * 4, 40, 40), i == 7);
    endtask

    // Clustered sets with random content, mixed with fully random boxes.
    task automatic test_random(input int n_items);
        int done, set_len, ncent, c, jit, dx, dy, dw, dh, pick;
        int cx [4];
        int cy [4];
        int cw [4];
        int ch [4];
        nms_box_t b;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)      write_threshold(0);
                else if (pick == 1) write_threshold(256);
                else if (pick == 2) write_threshold($urandom_range(0, 511));
                else                write_threshold($urandom_range(60, 200));
            end
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80)
                                                  : $urandom_range(1, 40);
            ncent = $urandom_range(1, 4);
            for (int k = 0; k < ncent; k++) begin
                cx[k] = $urandom_range(0, 16000);
                cx[k] -= 8000;
                cy[k] = $urandom_range(0, 16000);
                cy[k] -= 8000;
                cw[k] = $urandom_range(4, 300);
                ch[k] = $urandom_range(4, 300);
            end
            for (int i = 0; i < set_len; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    b = mk_box($urandom_range(0, 16383), $urandom_range(0, 16383),
                               $urandom_range(0, 8191), $urandom_range(0, 8191));
                end else begin
                    c   = $urandom_range(0, ncent - 1);
                    jit = (cw[c] / 8 > 0) ? cw[c] / 8 : 1;
                    dx  = $urandom_range(0, 2 * jit);
                    dy  = $urandom_range(0, 2 * jit);
                    dw  = $urandom_range(0, 2 * jit);
                    dh  = $urandom_range(0, 2 * jit);
                    b = mk_box(cx[c] + dx - jit, cy[c] + dy - jit,
                               cw[c] + dw - jit, ch[c] + dh - jit);
                end
                send_box(b, i == set_len - 1);
            end
            done += set_len;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        test_directed();
        test_threshold_sweep();
        test_table_full();
        write_threshold(115);
        test_long_set();
        test_backpressure();
        test_random(600);
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        test_random(200);
        drain_results();
        repeat (64) @(posedge aclk);
        $display("Checked %0d results for %0d boxes in %0d sets: %0d kept, %0d suppressed,",
                 results_seen, boxes_sent, sets_closed, kept_seen, supp_seen);
        $display("%0d table overflows; threshold written %0d times, highest index %0d.",
                 ovf_seen, thr_writes, max_idx_seen);
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d results pending.", verdict_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gbs_pkg.sv
rtl/core/gbs_table.sv
rtl/core/gbs_geom.sv
rtl/core/gbs_mult.sv
rtl/core/greedy_box_suppression.sv
dv/tb.sv
